// File: rtl/ssd_quantized_box_decode_unit_defines.svh
// ----------------------------------------------------------------------------
// ssd quantized box decode assertion macros
// shared assertion wrappers, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef SSD_QUANTIZED_BOX_DECODE_UNIT_DEFINES_SVH
`define SSD_QUANTIZED_BOX_DECODE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SQBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SQBD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define SQBD_ASSERT(lbl, prop, msg)
`define SQBD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: rtl/sqbd_pkg.sv
// ----------------------------------------------------------------------------
// sqbd_pkg
// shared types of the box decode unit: configuration and queued request
// ----------------------------------------------------------------------------
package sqbd_pkg;

  localparam logic [7:0] CFG_MIN_CONFIDENCE = 8'd0;
  localparam logic [7:0] CFG_DELTA_OFFSET   = 8'd1;
  localparam logic [7:0] CFG_DELTA_SCALE    = 8'd2;
  localparam logic [7:0] CFG_SCORE_SCALE    = 8'd3;

  typedef struct packed {
    logic        [7:0]  min_confidence;
    logic signed [7:0]  delta_offset;
    logic        [15:0] delta_scale;
    logic        [15:0] score_scale;
  } sqbd_cfg_t;

  typedef struct packed {
    logic        [7:0]  delta_y;
    logic        [7:0]  delta_x;
    logic        [7:0]  delta_h;
    logic        [7:0]  delta_w;
    logic signed [15:0] prior_ymin;
    logic signed [15:0] prior_xmin;
    logic signed [15:0] prior_ymax;
    logic signed [15:0] prior_xmax;
    logic        [7:0]  confidence;
    logic        [6:0]  label;
    logic        [7:0]  batch;
    logic               keep;
  } sqbd_item_t;

endpackage

// File: rtl/sqbd_front.sv
// ----------------------------------------------------------------------------
// sqbd_front
// input register: accepts candidates, classifies them and feeds the queue
// ----------------------------------------------------------------------------
`include "ssd_quantized_box_decode_unit_defines.svh"

module sqbd_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic        [7:0]         delta_y_i,
  input  logic        [7:0]         delta_x_i,
  input  logic        [7:0]         delta_h_i,
  input  logic        [7:0]         delta_w_i,
  input  logic signed [15:0]        prior_ymin_i,
  input  logic signed [15:0]        prior_xmin_i,
  input  logic signed [15:0]        prior_ymax_i,
  input  logic signed [15:0]        prior_xmax_i,
  input  logic        [7:0]         confidence_byte_i,
  input  logic        [6:0]         class_id_i,
  input  logic        [7:0]         batch_index_i,
  input  logic        [7:0]         min_confidence_i,
  input  logic                      full_i,
  output logic                      push_o,
  output sqbd_pkg::sqbd_item_t      item_o
);
  import sqbd_pkg::*;

  localparam int CLASS_COUNT = 128;

  logic       front_vld_q, front_vld_d;
  sqbd_item_t front_q, front_d;
  logic       load;
  logic       keep;

  assign keep = (confidence_byte_i >= min_confidence_i) && (class_id_i != 7'd0) &&
                ({2'b00, class_id_i} < 9'(CLASS_COUNT));

  assign in_stall_o = front_vld_q && full_i;
  assign push_o     = front_vld_q && !full_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    front_d            = front_q;
    front_d.delta_y    = delta_y_i;
    front_d.delta_x    = delta_x_i;
    front_d.delta_h    = delta_h_i;
    front_d.delta_w    = delta_w_i;
    front_d.prior_ymin = prior_ymin_i;
    front_d.prior_xmin = prior_xmin_i;
    front_d.prior_ymax = prior_ymax_i;
    front_d.prior_xmax = prior_xmax_i;
    front_d.confidence = confidence_byte_i;
    front_d.label      = class_id_i;
    front_d.batch      = batch_index_i;
    front_d.keep       = keep;
    front_vld_d        = load || (front_vld_q && !push_o);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_vld_q <= 1'b0;
    end else begin
      front_vld_q <= front_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      front_q <= front_d;
    end
  end

  assign item_o = front_q;

  `SQBD_ASSERT(a_front_accept_held, load |=> front_vld_q, "accepted request not registered")
  `SQBD_ASSERT(a_front_blocked_keeps, (front_vld_q && full_i) |=>
               (front_vld_q && $stable(front_q)), "blocked request lost")

endmodule

// File: rtl/sqbd_queue.sv
// ----------------------------------------------------------------------------
// sqbd_queue
// short fifo between the front register and the decode pipeline
// ----------------------------------------------------------------------------
`include "ssd_quantized_box_decode_unit_defines.svh"

module sqbd_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  sqbd_pkg::sqbd_item_t item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output sqbd_pkg::sqbd_item_t item_o
);
  import sqbd_pkg::*;

  localparam int QUEUE_DEPTH = 4;
  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  sqbd_item_t        mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  assign full_o  = (count_q == CntW'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  `SQBD_ASSERT(a_queue_no_overflow, !(push_i && full_o && !pop_i), "push into full queue")
  `SQBD_ASSERT(a_queue_no_underflow, pop_i |-> valid_o, "pop from empty queue")

endmodule

// File: rtl/sqbd_axis.sv
// ----------------------------------------------------------------------------
// sqbd_axis
// thirteen stage decode of one axis: dequantise, centre shift, exp scaling
// ----------------------------------------------------------------------------
module sqbd_axis #(
  parameter int EXP_TABLE_ENTRIES = 256
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [7:0]  delta_offset_i,
  input  logic        [15:0] delta_scale_i,
  input  logic signed [15:0] lo_i,
  input  logic signed [15:0] hi_i,
  input  logic        [7:0]  dc_i,
  input  logic        [7:0]  ds_i,
  output logic signed [15:0] lo_o,
  output logic signed [15:0] hi_o
);
  import sqbd_pkg::*;

  localparam int IdxW      = $clog2(EXP_TABLE_ENTRIES + 1);
  localparam int SizeTaps  = 10;
  localparam int CtrTaps   = 8;
  localparam int KTaps     = 5;
  localparam int CenTaps   = 4;
  localparam int CBytes    = 5;
  localparam int SBytes    = 3;
  localparam int DIV_CENTRE = 10;
  localparam int DIV_SIZE   = 5;
  localparam logic [17:0] LOG2E_Q16 = 18'd94548;
  localparam logic [50:0] HALF_CAP  = 51'd1 << 50;

  function automatic logic signed [23:0] dequant(input logic [7:0] raw,
                                                 input logic signed [7:0] off,
                                                 input logic [15:0] scale);
    logic signed [8:0]  d;
    logic signed [25:0] p;
    d = $signed({raw[7], raw}) - $signed({off[7], off});
    p = d * $signed({1'b0, scale});
    if (p > 26'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (p < -26'sd8388608) begin
      return 24'sh800000;
    end
    return p[23:0];
  endfunction

  function automatic logic [11:0] div10_byte(input logic [3:0] rem, input logic [7:0] din);
    logic [4:0] r;
    logic [7:0] q;
    r = {1'b0, rem};
    q = '0;
    for (int i = 7; i >= 0; i--) begin
      r = {r[3:0], din[i]};
      if (r >= 5'(DIV_CENTRE)) begin
        q[i] = 1'b1;
        r    = r - 5'(DIV_CENTRE);
      end
    end
    return {q, r[3:0]};
  endfunction

  function automatic logic [10:0] div5_byte(input logic [2:0] rem, input logic [7:0] din);
    logic [3:0] r;
    logic [7:0] q;
    r = {1'b0, rem};
    q = '0;
    for (int i = 7; i >= 0; i--) begin
      r = {r[2:0], din[i]};
      if (r >= 4'(DIV_SIZE)) begin
        q[i] = 1'b1;
        r    = r - 4'(DIV_SIZE);
      end
    end
    return {q, r[2:0]};
  endfunction

  function automatic logic [31:0] exp2_entry(input int unsigned i);
    logic [63:0] z;
    logic [63:0] term;
    logic [63:0] sum;
    z    = (64'(i) * 64'd744261118) / EXP_TABLE_ENTRIES;
    term = 64'd1 << 30;
    sum  = term;
    for (int j = 1; j <= 20; j++) begin
      term = ((term * z) >> 30) / 64'(j);
      sum  = sum + term;
    end
    return sum[31:0];
  endfunction

  function automatic logic signed [15:0] to_q14(input logic signed [53:0] v);
    logic signed [53:0] r;
    r = (v + 54'sd32768) >>> 16;
    if (r > 54'sd32767) begin
      return 16'sh7FFF;
    end else if (r < -54'sd32768) begin
      return 16'sh8000;
    end
    return r[15:0];
  endfunction

  logic [31:0] exp_tab [EXP_TABLE_ENTRIES + 1];

  for (genvar g = 0; g <= EXP_TABLE_ENTRIES; g++) begin : g_tab
    assign exp_tab[g] = exp2_entry(g);
  end

  logic signed [23:0] dqc_q, dqs_q;
  logic signed [16:0] size_q [SizeTaps];
  logic signed [31:0] ctr_q [CtrTaps];
  logic signed [40:0] prodc_q;
  logic        [23:0] mags_q;
  logic               negs_q;
  logic        [39:0] magc_q;
  logic               negc_q;
  logic        [39:0] cmag_q [CBytes];
  logic        [39:0] cquo_q [CBytes];
  logic        [3:0]  crem_q [CBytes];
  logic               cneg_q [CBytes];
  logic        [23:0] smag_q [SBytes];
  logic        [23:0] squo_q [SBytes];
  logic        [2:0]  srem_q [SBytes];
  logic               sneg_q [SBytes];
  logic signed [40:0] y_q;
  logic signed [8:0]  k_q [KTaps];
  logic [IdxW-1:0]    idx_q;
  logic        [31:0] remf7_q, remf8_q;
  logic        [31:0] a8_q, b8_q, a9_q;
  logic        [63:0] interp_q;
  logic        [32:0] v_q;
  logic signed [50:0] p_q;
  logic signed [51:0] half_q;
  logic signed [39:0] cen_q [CenTaps];
  logic signed [15:0] lo_q, hi_q;

  logic signed [16:0] lo_x, hi_x, size_d, sum_d;
  logic signed [40:0] prodc_abs;
  logic signed [23:0] dqs_abs;
  logic        [39:0] cmag_in [CBytes];
  logic        [39:0] cquo_in [CBytes];
  logic        [3:0]  crem_in [CBytes];
  logic               cneg_in [CBytes];
  logic        [39:0] cquo_d [CBytes];
  logic        [3:0]  crem_d [CBytes];
  logic        [23:0] smag_in [SBytes];
  logic        [23:0] squo_in [SBytes];
  logic        [2:0]  srem_in [SBytes];
  logic               sneg_in [SBytes];
  logic        [23:0] squo_d [SBytes];
  logic        [2:0]  srem_d [SBytes];
  logic signed [22:0] e_w;
  logic        [22:0] sq_w;
  logic signed [39:0] cq_w, cen_d;
  logic [31+IdxW:0]   pos_w;
  logic signed [51:0] half_d;

  assign lo_x   = {lo_i[15], lo_i};
  assign hi_x   = {hi_i[15], hi_i};
  assign size_d = hi_x - lo_x;
  assign sum_d  = hi_x + lo_x;

  assign prodc_abs = prodc_q[40] ? -prodc_q : prodc_q;
  assign dqs_abs   = dqs_q[23] ? -dqs_q : dqs_q;

  always_comb begin
    logic [11:0] cres;
    logic [10:0] sres;
    cmag_in[0] = magc_q;
    cquo_in[0] = '0;
    crem_in[0] = '0;
    cneg_in[0] = negc_q;
    for (int b = 1; b < CBytes; b++) begin
      cmag_in[b] = cmag_q[b-1];
      cquo_in[b] = cquo_q[b-1];
      crem_in[b] = crem_q[b-1];
      cneg_in[b] = cneg_q[b-1];
    end
    for (int b = 0; b < CBytes; b++) begin
      cres      = div10_byte(crem_in[b], cmag_in[b][8*(CBytes-1-b) +: 8]);
      cquo_d[b] = cquo_in[b] | ({32'd0, cres[11:4]} << (8*(CBytes-1-b)));
      crem_d[b] = cres[3:0];
    end
    smag_in[0] = mags_q;
    squo_in[0] = '0;
    srem_in[0] = '0;
    sneg_in[0] = negs_q;
    for (int b = 1; b < SBytes; b++) begin
      smag_in[b] = smag_q[b-1];
      squo_in[b] = squo_q[b-1];
      srem_in[b] = srem_q[b-1];
      sneg_in[b] = sneg_q[b-1];
    end
    for (int b = 0; b < SBytes; b++) begin
      sres      = div5_byte(srem_in[b], smag_in[b][8*(SBytes-1-b) +: 8]);
      squo_d[b] = squo_in[b] | ({16'd0, sres[10:3]} << (8*(SBytes-1-b)));
      srem_d[b] = sres[2:0];
    end
  end

  assign sq_w  = squo_q[SBytes-1][22:0];
  assign e_w   = sneg_q[SBytes-1] ? -$signed(sq_w) : $signed(sq_w);
  assign cq_w  = cneg_q[CBytes-1] ? -$signed(cquo_q[CBytes-1]) : $signed(cquo_q[CBytes-1]);
  assign cen_d = $signed({{8{ctr_q[CtrTaps-1][31]}}, ctr_q[CtrTaps-1]}) + cq_w;
  assign pos_w = y_q[31:0] * IdxW'(EXP_TABLE_ENTRIES);

  // power of two scaling with rounding on the way down and a cap on the way up
  always_comb begin
    logic signed [50:0] pabs;
    logic        [49:0] mag;
    logic signed [9:0]  s;
    logic        [9:0]  sh;
    logic        [99:0] wide;
    logic        [63:0] tmp;
    logic        [50:0] hmag;
    pabs = p_q[50] ? -p_q : p_q;
    mag  = pabs[49:0];
    s    = $signed({k_q[KTaps-1][8], k_q[KTaps-1]}) - 10'sd15;
    sh   = 10'(-s);
    wide = '0;
    tmp  = '0;
    if (!s[9]) begin
      if ((mag != '0) && (s >= 10'sd50)) begin
        hmag = HALF_CAP;
      end else begin
        wide = 100'(mag) << s[5:0];
        hmag = ((|wide[99:51]) || (wide[50] && (|wide[49:0]))) ? HALF_CAP : wide[50:0];
      end
    end else begin
      if (sh > 10'd62) begin
        hmag = '0;
      end else begin
        tmp  = 64'(mag) + (64'd1 << (sh[5:0] - 6'd1));
        hmag = 51'(tmp >> sh[5:0]);
      end
    end
    half_d = p_q[50] ? -$signed({1'b0, hmag}) : $signed({1'b0, hmag});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dqc_q     <= dequant(dc_i, delta_offset_i, delta_scale_i);
      dqs_q     <= dequant(ds_i, delta_offset_i, delta_scale_i);
      size_q[0] <= size_d;
      ctr_q[0]  <= {sum_d, 15'd0};
      for (int t = 1; t < SizeTaps; t++) begin
        size_q[t] <= size_q[t-1];
      end
      for (int t = 1; t < CtrTaps; t++) begin
        ctr_q[t] <= ctr_q[t-1];
      end
      prodc_q <= dqc_q * size_q[0];
      mags_q  <= dqs_abs[23:0] + 24'd2;
      negs_q  <= dqs_q[23];
      magc_q  <= prodc_abs[39:0] + 40'd5;
      negc_q  <= prodc_q[40];
      for (int b = 0; b < CBytes; b++) begin
        cmag_q[b] <= cmag_in[b];
        cquo_q[b] <= cquo_d[b];
        crem_q[b] <= crem_d[b];
        cneg_q[b] <= cneg_in[b];
      end
      for (int b = 0; b < SBytes; b++) begin
        smag_q[b] <= smag_in[b];
        squo_q[b] <= squo_d[b];
        srem_q[b] <= srem_d[b];
        sneg_q[b] <= sneg_in[b];
      end
      y_q      <= e_w * $signed(LOG2E_Q16);
      k_q[0]   <= y_q[40:32];
      for (int t = 1; t < KTaps; t++) begin
        k_q[t] <= k_q[t-1];
      end
      idx_q    <= pos_w[32 +: IdxW];
      remf7_q  <= pos_w[31:0];
      a8_q     <= exp_tab[idx_q];
      b8_q     <= exp_tab[idx_q + 1'b1];
      remf8_q  <= remf7_q;
      interp_q <= (b8_q - a8_q) * remf8_q;
      a9_q     <= a8_q;
      v_q      <= {1'b0, a9_q} + {1'b0, interp_q[63:32]};
      p_q      <= $signed({1'b0, v_q}) * size_q[SizeTaps-1];
      half_q   <= half_d;
      cen_q[0] <= cen_d;
      for (int t = 1; t < CenTaps; t++) begin
        cen_q[t] <= cen_q[t-1];
      end
      lo_q <= to_q14(54'(cen_q[CenTaps-1]) - 54'(half_q));
      hi_q <= to_q14(54'(cen_q[CenTaps-1]) + 54'(half_q));
    end
  end

  assign lo_o = lo_q;
  assign hi_o = hi_q;

endmodule

// File: rtl/sqbd_back.sv
// ----------------------------------------------------------------------------
// sqbd_back
// decode pipeline: drains the queue, runs both axes, holds the result
// ----------------------------------------------------------------------------
module sqbd_back #(
  parameter int EXP_TABLE_ENTRIES = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sqbd_pkg::sqbd_cfg_t  cfg_i,
  input  logic                 q_valid_i,
  input  sqbd_pkg::sqbd_item_t q_item_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 keep_o,
  output logic        [7:0]    batch_out_o,
  output logic signed [15:0]   box_ymin_o,
  output logic signed [15:0]   box_xmin_o,
  output logic signed [15:0]   box_ymax_o,
  output logic signed [15:0]   box_xmax_o,
  output logic        [23:0]   score_o,
  output logic        [6:0]    label_out_o
);
  import sqbd_pkg::*;

  localparam int AXIS_LATENCY = 13;

  typedef struct packed {
    logic       keep;
    logic [7:0] confidence;
    logic [6:0] label;
    logic [7:0] batch;
  } sqbd_meta_t;

  logic               vld_q [AXIS_LATENCY];
  sqbd_meta_t         meta_q [AXIS_LATENCY];
  sqbd_meta_t         meta_d;
  logic [23:0]        score_q;
  logic               adv;
  logic signed [15:0] ymin, ymax, xmin, xmax;

  assign adv   = !(vld_q[AXIS_LATENCY-1] && out_stall_i);
  assign pop_o = q_valid_i && adv;

  assign meta_d = '{keep: q_item_i.keep, confidence: q_item_i.confidence,
                    label: q_item_i.label, batch: q_item_i.batch};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < AXIS_LATENCY; s++) begin
        vld_q[s] <= 1'b0;
      end
    end else if (adv) begin
      vld_q[0] <= q_valid_i;
      for (int s = 1; s < AXIS_LATENCY; s++) begin
        vld_q[s] <= vld_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      meta_q[0] <= meta_d;
      for (int s = 1; s < AXIS_LATENCY; s++) begin
        meta_q[s] <= meta_q[s-1];
      end
      score_q <= meta_q[AXIS_LATENCY-2].keep ?
                 (24'(meta_q[AXIS_LATENCY-2].confidence) * 24'(cfg_i.score_scale)) : '0;
    end
  end

  sqbd_axis #(
    .EXP_TABLE_ENTRIES(EXP_TABLE_ENTRIES)
  ) u_axis_y (
    .clk_i          (clk_i),
    .en_i           (adv),
    .delta_offset_i (cfg_i.delta_offset),
    .delta_scale_i  (cfg_i.delta_scale),
    .lo_i           (q_item_i.prior_ymin),
    .hi_i           (q_item_i.prior_ymax),
    .dc_i           (q_item_i.delta_y),
    .ds_i           (q_item_i.delta_h),
    .lo_o           (ymin),
    .hi_o           (ymax)
  );

  sqbd_axis #(
    .EXP_TABLE_ENTRIES(EXP_TABLE_ENTRIES)
  ) u_axis_x (
    .clk_i          (clk_i),
    .en_i           (adv),
    .delta_offset_i (cfg_i.delta_offset),
    .delta_scale_i  (cfg_i.delta_scale),
    .lo_i           (q_item_i.prior_xmin),
    .hi_i           (q_item_i.prior_xmax),
    .dc_i           (q_item_i.delta_x),
    .ds_i           (q_item_i.delta_w),
    .lo_o           (xmin),
    .hi_o           (xmax)
  );

  assign out_valid_o = vld_q[AXIS_LATENCY-1];
  assign keep_o      = meta_q[AXIS_LATENCY-1].keep;
  assign batch_out_o = meta_q[AXIS_LATENCY-1].batch;
  assign label_out_o = meta_q[AXIS_LATENCY-1].label;
  assign score_o     = score_q;
  assign box_ymin_o  = keep_o ? ymin : 16'sd0;
  assign box_xmin_o  = keep_o ? xmin : 16'sd0;
  assign box_ymax_o  = keep_o ? ymax : 16'sd0;
  assign box_xmax_o  = keep_o ? xmax : 16'sd0;

endmodule

// File: rtl/ssd_quantized_box_decode_unit.sv
// ----------------------------------------------------------------------------
// ssd_quantized_box_decode_unit
// decodes quantized ssd box deltas around their prior into saturated corners
//
//   channel   handshake                  payload
//   input     in_valid_i / in_stall_o    deltas, prior corners, confidence, class, batch
//   output    out_valid_o / out_stall_i  keep, corners, score, label, batch
//   config    cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// one request per cycle sustained while out_stall_i is low; from acceptance
// a result passes the input register, one queue slot and the 13 stage axis
// pipeline (byte wise division by ten of the centre shift and the exp table)
// a stalled result freezes the pipeline; the 4 entry queue keeps accepting
// until it fills. reset empties the queue and pipeline and loads register
// defaults; no clearing pass
// ----------------------------------------------------------------------------
module ssd_quantized_box_decode_unit #(
  parameter int EXP_TABLE_ENTRIES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic        [7:0]  delta_y_i,
  input  logic        [7:0]  delta_x_i,
  input  logic        [7:0]  delta_h_i,
  input  logic        [7:0]  delta_w_i,
  input  logic signed [15:0] prior_ymin_i,
  input  logic signed [15:0] prior_xmin_i,
  input  logic signed [15:0] prior_ymax_i,
  input  logic signed [15:0] prior_xmax_i,
  input  logic        [7:0]  confidence_byte_i,
  input  logic        [6:0]  class_id_i,
  input  logic        [7:0]  batch_index_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               keep_o,
  output logic        [7:0]  batch_out_o,
  output logic signed [15:0] box_ymin_o,
  output logic signed [15:0] box_xmin_o,
  output logic signed [15:0] box_ymax_o,
  output logic signed [15:0] box_xmax_o,
  output logic        [23:0] score_o,
  output logic        [6:0]  label_out_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic        [7:0]  cfg_index_i,
  input  logic        [15:0] cfg_data_i
);
  import sqbd_pkg::*;

  sqbd_cfg_t  cfg_q, cfg_d;
  sqbd_item_t front_item, queue_item;
  logic       push, full, pop, queue_valid;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MIN_CONFIDENCE: cfg_d.min_confidence = cfg_data_i[7:0];
        CFG_DELTA_OFFSET:   cfg_d.delta_offset   = $signed(cfg_data_i[7:0]);
        CFG_DELTA_SCALE:    cfg_d.delta_scale    = cfg_data_i;
        CFG_SCORE_SCALE:    cfg_d.score_scale    = cfg_data_i;
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_confidence <= 8'd76;
      cfg_q.delta_offset   <= 8'sd0;
      cfg_q.delta_scale    <= 16'd256;
      cfg_q.score_scale    <= 16'd257;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sqbd_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .delta_y_i         (delta_y_i),
    .delta_x_i         (delta_x_i),
    .delta_h_i         (delta_h_i),
    .delta_w_i         (delta_w_i),
    .prior_ymin_i      (prior_ymin_i),
    .prior_xmin_i      (prior_xmin_i),
    .prior_ymax_i      (prior_ymax_i),
    .prior_xmax_i      (prior_xmax_i),
    .confidence_byte_i (confidence_byte_i),
    .class_id_i        (class_id_i),
    .batch_index_i     (batch_index_i),
    .min_confidence_i  (cfg_q.min_confidence),
    .full_i            (full),
    .push_o            (push),
    .item_o            (front_item)
  );

  sqbd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .item_o  (queue_item)
  );

  sqbd_back #(
    .EXP_TABLE_ENTRIES(EXP_TABLE_ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (queue_valid),
    .q_item_i    (queue_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .keep_o      (keep_o),
    .batch_out_o (batch_out_o),
    .box_ymin_o  (box_ymin_o),
    .box_xmin_o  (box_xmin_o),
    .box_ymax_o  (box_ymax_o),
    .box_xmax_o  (box_xmax_o),
    .score_o     (score_o),
    .label_out_o (label_out_o)
  );

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the quantized ssd box decoder: a queue-fed driver
// presents candidates under random idling, a scoreboard predicts each
// decoded box and compares it with the result stream, while the four
// registers are rewritten between phases, extremes included
// ----------------------------------------------------------------------------
module tb;
  import sqbd_pkg::*;

  localparam int unsigned EXP_ENTRIES = 256;
  localparam logic [7:0] REG_UNMAPPED    = 8'd9;
  localparam longint LOG2E_Q16 = 94548;
  localparam longint ONE_Q32   = 64'sd4294967296;
  localparam longint HALF_CAP  = 64'sd1 << 50;

  typedef struct {
    logic [7:0]         dy, dx, dh, dw;
    logic signed [15:0] ymin, xmin, ymax, xmax;
    logic [7:0]         conf;
    logic [6:0]         cls;
    logic [7:0]         batch;
  } candidate_t;

  typedef struct {
    logic               keep;
    logic [7:0]         batch;
    logic signed [15:0] ymin, xmin, ymax, xmax;
    logic [23:0]        score;
    logic [6:0]         label;
  } decoded_box_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [7:0] delta_y_i = '0, delta_x_i = '0, delta_h_i = '0, delta_w_i = '0;
  logic signed [15:0] prior_ymin_i = '0, prior_xmin_i = '0, prior_ymax_i = '0;
  logic signed [15:0] prior_xmax_i = '0;
  logic [7:0] confidence_byte_i = '0;
  logic [6:0] class_id_i = '0;
  logic [7:0] batch_index_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic keep_o;
  logic [7:0] batch_out_o;
  logic signed [15:0] box_ymin_o, box_xmin_o, box_ymax_o, box_xmax_o;
  logic [23:0] score_o;
  logic [6:0] label_out_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [7:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  ssd_quantized_box_decode_unit dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor copy of the registers
  logic [7:0]        min_conf = 8'd76;
  logic signed [7:0] delta_ofs = 8'sd0;
  logic [15:0]       delta_scale = 16'd256;
  logic [15:0]       score_scale = 16'd257;

  longint unsigned exp2_tab [0:EXP_ENTRIES];
  candidate_t   pending_requests[$];
  decoded_box_t expected_boxes[$];
  int sender_idle_pct = 21, receiver_idle_pct = 74;
  bit hold_requests = 1'b0;
  bit request_taken = 1'b0;
  int mismatches = 0, requests_sent = 0, boxes_seen = 0, boxes_kept = 0;

  function automatic longint round_div(longint v, longint d);
    longint m;
    m = v < 0 ? -v : v;
    m = (m + d / 2) / d;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint floor_div(longint v, longint d);
    if (v >= 0) return v / d;
    return -((-v + d - 1) / d);
  endfunction

  function automatic longint dequantize(logic [7:0] b);
    longint d;
    d = (longint'($signed(b)) - longint'(delta_ofs)) * longint'(delta_scale);
    if (d > 8388607) d = 8388607;
    if (d < -8388608) d = -8388608;
    return d;
  endfunction

  function automatic longint half_extent(longint e, longint size);
    longint y, k, p, s;
    longint unsigned frac, pos, idx, rem, a, b, v, mag;
    y = e * LOG2E_Q16;
    k = floor_div(y, ONE_Q32);
    frac = y - k * ONE_Q32;
    pos = frac * EXP_ENTRIES;
    idx = pos >> 32;
    rem = pos & 64'hFFFF_FFFF;
    a = exp2_tab[idx];
    b = exp2_tab[idx + 1];
    v = a + (((b - a) * rem) >> 32);
    p = longint'(v) * size;
    mag = p < 0 ? -p : p;
    s = k - 15;
    if (s >= 0) begin
      if (mag != 0 && (s >= 50 || mag > (HALF_CAP >> s))) mag = HALF_CAP;
      else mag = mag << s;
    end else if (-s > 62) begin
      mag = 0;
    end else begin
      mag = (mag + (64'd1 << (-s - 1))) >> (-s);
    end
    return p < 0 ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic signed [15:0] to_q14(longint v);
    longint r;
    r = floor_div(v + 32768, 65536);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic void decode_axis(input logic signed [15:0] lo,
                                      input logic signed [15:0] hi,
                                      input logic [7:0] dc, input logic [7:0] ds,
                                      output logic signed [15:0] out_lo,
                                      output logic signed [15:0] out_hi);
    longint size, cen, half;
    size = longint'(hi) - longint'(lo);
    cen = (longint'(lo) + longint'(hi)) * 32768 + round_div(dequantize(dc) * size, 10);
    half = half_extent(round_div(dequantize(ds), 5), size);
    out_lo = to_q14(cen - half);
    out_hi = to_q14(cen + half);
  endfunction

  function automatic decoded_box_t decode_candidate(candidate_t c);
    decoded_box_t r;
    r = '{keep: 1'b0, batch: c.batch, ymin: '0, xmin: '0, ymax: '0, xmax: '0,
          score: '0, label: c.cls};
    if (c.conf >= min_conf && c.cls != 0) begin
      r.keep = 1'b1;
      decode_axis(c.ymin, c.ymax, c.dy, c.dh, r.ymin, r.ymax);
      decode_axis(c.xmin, c.xmax, c.dx, c.dw, r.xmin, r.xmax);
      r.score = 24'(c.conf) * 24'(score_scale);
    end
    return r;
  endfunction

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !request_taken) begin
      end else if (pending_requests.size() > 0 && !hold_requests &&
                   $urandom_range(99) >= sender_idle_pct) begin
        in_valid_i <= 1'b1;
        delta_y_i <= pending_requests[0].dy;
        delta_x_i <= pending_requests[0].dx;
        delta_h_i <= pending_requests[0].dh;
        delta_w_i <= pending_requests[0].dw;
        prior_ymin_i <= pending_requests[0].ymin;
        prior_xmin_i <= pending_requests[0].xmin;
        prior_ymax_i <= pending_requests[0].ymax;
        prior_xmax_i <= pending_requests[0].xmax;
        confidence_byte_i <= pending_requests[0].conf;
        class_id_i <= pending_requests[0].cls;
        batch_index_i <= pending_requests[0].batch;
      end else begin
        in_valid_i <= 1'b0;
      end
      request_taken = 1'b0;
      out_stall_i <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  // acceptance and result checking
  always @(posedge clk_i) begin
    decoded_box_t want;
    decoded_box_t pred;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        pred = decode_candidate(pending_requests.pop_front());
        expected_boxes = {expected_boxes, pred};
        request_taken = 1'b1;
        requests_sent++;
      end
      if (out_valid_o && !out_stall_i) begin
        boxes_seen++;
        if (expected_boxes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result, batch %0d", batch_out_o);
        end else begin
          want = expected_boxes.pop_front();
          if (keep_o) boxes_kept++;
          if (keep_o !== want.keep || batch_out_o !== want.batch ||
              box_ymin_o !== want.ymin || box_xmin_o !== want.xmin ||
              box_ymax_o !== want.ymax || box_xmax_o !== want.xmax ||
              score_o !== want.score || label_out_o !== want.label) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp keep %0b b %0d y %0d x %0d Y %0d X %0d s %0d l %0d",
                       want.keep, want.batch, want.ymin, want.xmin, want.ymax,
                       want.xmax, want.score, want.label, "\n          got keep %0b ",
                       keep_o, "b %0d y %0d x %0d Y %0d X %0d s %0d l %0d",
                       batch_out_o, box_ymin_o, box_xmin_o, box_ymax_o, box_xmax_o,
                       score_o, label_out_o);
          end
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_requests.size() > 0 || expected_boxes.size() > 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_MIN_CONFIDENCE: min_conf = data[7:0];
      CFG_DELTA_OFFSET:   delta_ofs = data[7:0];
      CFG_DELTA_SCALE:    delta_scale = data;
      CFG_SCORE_SCALE:    score_scale = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_regs(input logic [7:0] mc, input logic [7:0] ofs,
                          input logic [15:0] ds, input logic [15:0] ss);
    wait_drained();
    write_reg(CFG_MIN_CONFIDENCE, {8'h00, mc});
    write_reg(CFG_DELTA_OFFSET, {8'h00, ofs});
    write_reg(CFG_DELTA_SCALE, ds);
    write_reg(CFG_SCORE_SCALE, ss);
  endtask

  task automatic queue_candidate(input logic [7:0] dy, dx, dh, dw,
                                 input logic signed [15:0] ymin, xmin, ymax, xmax,
                                 input logic [7:0] conf, input logic [6:0] cls,
                                 input logic [7:0] batch);
    candidate_t c;
    c = '{dy, dx, dh, dw, ymin, xmin, ymax, xmax, conf, cls, batch};
    pending_requests = {pending_requests, c};
  endtask

  task automatic queue_random(input int count);
    logic signed [15:0] lo [2], hi [2];
    repeat (count) begin
      for (int a = 0; a < 2; a++) begin
        if ($urandom_range(9) < 7) begin
          lo[a] = 16'($urandom_range(16383));
          hi[a] = lo[a] + 16'($urandom_range(12000));
        end else begin
          lo[a] = 16'($urandom);
          hi[a] = 16'($urandom);
        end
      end
      queue_candidate(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), lo[0],
                      lo[1], hi[0], hi[1], 8'($urandom),
                      ($urandom_range(15) == 0) ? 7'd0 : 7'($urandom_range(127)),
                      8'($urandom));
    end
  endtask

  initial begin
    longint unsigned z, term, sum;
    for (int i = 0; i <= EXP_ENTRIES; i++) begin
      z = (longint'(i) * 744261118) / EXP_ENTRIES;
      term = 64'd1 << 30;
      sum = term;
      for (int j = 1; j <= 20; j++) begin
        term = ((term * z) >> 30) / j;
        sum += term;
      end
      exp2_tab[i] = sum;
    end
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset defaults, directed corners
    queue_candidate(8'h00, 8'h00, 8'h00, 8'h00, 16'sd0, 16'sd0, 16'sd8192, 16'sd8192,
                    8'd76, 7'd1, 8'd0);
    queue_candidate(8'h7f, 8'h7f, 8'h7f, 8'h7f, 16'sd4096, 16'sd4096, 16'sd12288,
                    16'sd12288, 8'd255, 7'd127, 8'd255);
    queue_candidate(8'h80, 8'h80, 8'h80, 8'h80, 16'sd4096, 16'sd2000, 16'sd12288,
                    16'sd9000, 8'd200, 7'd5, 8'd1);
    queue_candidate(8'hff, 8'h01, 8'hff, 8'h01, 16'sd1000, 16'sd2000, 16'sd5000,
                    16'sd3000, 8'd100, 7'd9, 8'd2);
    queue_candidate(8'h10, 8'h10, 8'h10, 8'h10, 16'sd0, 16'sd0, 16'sd8192, 16'sd8192,
                    8'd75, 7'd3, 8'd3);
    queue_candidate(8'h10, 8'h10, 8'h10, 8'h10, 16'sd0, 16'sd0, 16'sd8192, 16'sd8192,
                    8'd255, 7'd0, 8'd4);
    queue_candidate(8'h20, 8'he0, 8'h30, 8'hd0, 16'sd12000, 16'sd9000, 16'sd3000,
                    16'sd1000, 8'd150, 7'd64, 8'd5);
    queue_candidate(8'h7f, 8'h80, 8'h7f, 8'h7f, -16'sd32768, -16'sd32768, 16'sd32767,
                    16'sd32767, 8'd255, 7'd2, 8'h5a);
    queue_candidate(8'h80, 8'h7f, 8'h80, 8'h80, 16'sd32767, 16'sd32767, -16'sd32768,
                    -16'sd32768, 8'd255, 7'd2, 8'ha5);
    queue_candidate(8'h55, 8'haa, 8'h55, 8'haa, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                    8'd0, 7'd127, 8'd7);
    queue_candidate(8'h00, 8'h00, 8'h00, 8'h00, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                    8'd128, 7'd100, 8'd8);
    queue_random(250);

    set_regs(8'd0, 8'h80, 16'hffff, 16'hffff);
    queue_candidate(8'h7f, 8'h7f, 8'h7f, 8'h7f, -16'sd32768, -16'sd32768, 16'sd32767,
                    16'sd32767, 8'd0, 7'd1, 8'd9);
    queue_candidate(8'h80, 8'h80, 8'h80, 8'h80, 16'sd100, 16'sd100, 16'sd400,
                    16'sd400, 8'd255, 7'd0, 8'd10);
    queue_random(250);

    set_regs(8'd255, 8'h7f, 16'd0, 16'd0);
    queue_random(200);

    sender_idle_pct = 74;
    receiver_idle_pct = 21;
    set_regs(8'd30, 8'h05, 16'd1000, 16'd300);
    write_reg(REG_UNMAPPED, 16'hbeef);
    queue_random(150);
    hold_requests = 1'b1;
    while (expected_boxes.size() > 0 || in_valid_i) @(negedge clk_i);
    hold_requests = 1'b0;
    queue_random(150);

    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    set_regs(8'd90, 8'hf6, 16'd20000, 16'd4000);
    queue_random(300);

    set_regs(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
    queue_random(250);

    wait_drained();
    $display("%0d candidates decoded, %0d results checked, %0d kept, %0d mismatches",
             requests_sent, boxes_seen, boxes_kept, mismatches);
    $display("covered six register settings and three idling regimes");
    if (mismatches == 0 && expected_boxes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/sqbd_pkg.sv
rtl/sqbd_front.sv
rtl/sqbd_queue.sv
rtl/sqbd_axis.sv
rtl/sqbd_back.sv
rtl/ssd_quantized_box_decode_unit.sv
verif/tb.sv
